>>> src/fbcb_pkg.sv
// fbcb_pkg: shared constants and types for the float box to cell box block
// no dependencies
package fbcb_pkg;
  localparam int unsigned NUM_EDGES = 4;
  localparam int unsigned FRAC_BITS = 23;
  localparam logic [7:0] EXP_BIAS = 8'h7F;
  localparam logic [7:0] EXP_ALL1 = 8'hFF;
  localparam logic [31:0] INT_MIN_U = 32'h8000_0000;
  localparam logic [31:0] INT_MAX_U = 32'h7FFF_FFFF;
  localparam logic [31:0] MINUS_ONE = 32'hBF80_0000;

  typedef logic [31:0] word_t;
  typedef word_t [NUM_EDGES-1:0] edges_t;
endpackage

>>> src/fbcb_lane.sv
// fbcb_lane: floor of one ieee single edge, registered, then truncating int conversion
// depends on fbcb_pkg
module fbcb_lane (
  input  logic           clk,
  input  logic           en,
  input  fbcb_pkg::word_t bits_in,
  output fbcb_pkg::word_t int_out
);
  import fbcb_pkg::*;

  word_t       fl;
  word_t       fl_next;
  logic [7:0]  ef;
  logic [4:0]  e_s;
  logic [22:0] low;
  logic [23:0] mant;
  logic [7:0]  fe;
  logic [31:0] mag;

  // floor on the bit pattern
  always_comb begin
    ef = bits_in[30:23];
    low = '0;
    mant = '0;
    if (ef < EXP_BIAS) begin
      fl_next = (bits_in[31] && (bits_in[30:0] != '0)) ? MINUS_ONE : '0;
    end else if (ef >= EXP_BIAS + 8'd23) begin
      fl_next = bits_in;
    end else begin
      low = 23'h7F_FFFF >> (ef - EXP_BIAS);
      if (!bits_in[31]) begin
        fl_next = {bits_in[31:23], bits_in[22:0] & ~low};
      end else begin
        mant = ({1'b0, bits_in[22:0]} + {1'b0, low}) & ~{1'b0, low};
        fl_next = {1'b1, ef + {7'd0, mant[23]}, mant[22:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) fl <= fl_next;
  end

  // conversion stage, unbiased exponent only needed modulo 32 here
  always_comb begin
    fe = fl[30:23];
    e_s = fe[4:0] - EXP_BIAS[4:0];
    mag = {8'd0, 1'b1, fl[22:0]};
    if (fe == EXP_ALL1 || (fe >= EXP_BIAS + 8'd31)) begin
      int_out = INT_MIN_U;
    end else if (fe < EXP_BIAS) begin
      int_out = '0;
    end else begin
      if (e_s >= 5'd23) mag = mag << (e_s - 5'd23);
      else mag = mag >> (5'd23 - e_s);
      int_out = fl[31] ? (32'd0 - mag) : mag;
    end
  end
endmodule

>>> src/fbcb_merge.sv
// fbcb_merge: gathers lane results, applies saturating plus one to max edges
// depends on fbcb_pkg
module fbcb_merge (
  input  fbcb_pkg::edges_t lane_int,
  output fbcb_pkg::edges_t cells
);
  import fbcb_pkg::*;

  always_comb begin
    cells[0] = lane_int[0];
    cells[1] = lane_int[1];
    for (int i = 2; i < 4; i++) begin
      cells[i] = (lane_int[i] == INT_MAX_U) ? lane_int[i] : lane_int[i] + 32'd1;
    end
  end
endmodule

>>> src/float_box_to_cell_box_top.sv
// float_box_to_cell_box_top: top level, four floor lanes, merge and output register
// depends on fbcb_pkg, fbcb_lane, fbcb_merge
//
// slave channel s_axis carries a rectangle as four ieee single edge patterns,
// master channel m_axis returns the covering half-open cell rectangle as four
// signed 32-bit indices. each edge has its own lane: floor, register, then
// integer conversion; the merge adds one (saturating) to the max edges.
// the lane registers, then the output register, hold each result; one rectangle
// per cycle is accepted while s_axis_tready is high. the two stages each move
// whenever their output slot is empty or being taken, so a stall on m_axis_tready
// holds the output stage and pushes back on s_axis_tready only when both are full.
// reset clears the valid flags; payload registers are not reset.
module float_box_to_cell_box_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // min_x_bits, min_y_bits, max_x_bits, max_y_bits from the lowest bit up
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cell_min_x, cell_min_y, cell_max_x, cell_max_y from the lowest bit up
  output logic [127:0] m_axis_tdata
);
  import fbcb_pkg::*;

  logic   v1;
  logic   v2;
  logic   adv2;
  logic   adv1;
  edges_t lane_int;
  edges_t cells;
  edges_t out_reg;

  assign adv2 = !v2 || m_axis_tready;
  assign adv1 = !v1 || adv2;
  assign s_axis_tready = adv1;

  for (genvar g = 0; g < NUM_EDGES; g++) begin : g_lane
    fbcb_lane u_lane (
      .clk     (clk),
      .en      (adv1),
      .bits_in (s_axis_tdata[32*g +: 32]),
      .int_out (lane_int[g])
    );
  end

  fbcb_merge u_merge (.lane_int(lane_int), .cells(cells));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) v1 <= s_axis_tvalid;
      if (adv2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) out_reg <= cells;
  end

  assign m_axis_tvalid = v2;
  assign m_axis_tdata  = out_reg;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("ready low with empty output");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    v1 && !v2 |=> v2)
    else $error("stage one result lost");
endmodule

>>> tb/float_box_to_cell_box_top_tb.sv
// float_box_to_cell_box_top_tb: self-checking bench for the float box to cell box block
// depends on fbcb_pkg and float_box_to_cell_box_top; predicts each cell rectangle locally
module float_box_to_cell_box_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbcb_pkg::*;

  typedef struct packed {
    word_t max_y;
    word_t max_x;
    word_t min_y;
    word_t min_x;
  } rect_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  rect_t cell_rects_due[$];
  int    mismatches = 0;
  bit    sending_done = 1'b0;

  float_box_to_cell_box_top u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // floor on the bit pattern
  function automatic word_t floor_pattern(word_t b);
    int    e;
    logic  neg;
    word_t low;
    word_t mant;
    e = int'(b[30:23]) - int'(EXP_BIAS);
    neg = b[31];
    if (e < 0) return (neg && b[30:0] != 0) ? MINUS_ONE : 32'h0;
    if (e >= int'(FRAC_BITS)) return b;
    low = (32'h1 << (int'(FRAC_BITS) - e)) - 32'h1;
    if (!neg) return b & ~low;
    mant = ({9'h0, b[22:0]} + low) & ~low;
    e = e + int'(mant[23]) + int'(EXP_BIAS);
    return {1'b1, e[7:0], mant[22:0]};
  endfunction

  // truncating conversion, out of range and nan give the most negative integer
  function automatic word_t cell_index(word_t f);
    int    e;
    word_t mag;
    if (f[30:23] == EXP_ALL1) return INT_MIN_U;
    e = int'(f[30:23]) - int'(EXP_BIAS);
    if (e >= 31) return INT_MIN_U;
    if (e < 0) return 32'h0;
    mag = {8'h1, f[22:0]};
    if (e >= int'(FRAC_BITS)) mag = mag << (e - int'(FRAC_BITS));
    else mag = mag >> (int'(FRAC_BITS) - e);
    return f[31] ? (32'h0 - mag) : mag;
  endfunction

  function automatic word_t upper_bound(word_t v);
    return (v == INT_MAX_U) ? v : v + 32'h1;
  endfunction

  function automatic rect_t cover_rect(rect_t r);
    rect_t c;
    c.min_x = cell_index(floor_pattern(r.min_x));
    c.min_y = cell_index(floor_pattern(r.min_y));
    c.max_x = upper_bound(cell_index(floor_pattern(r.max_x)));
    c.max_y = upper_bound(cell_index(floor_pattern(r.max_y)));
    return c;
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // valid stays high across back-to-back items, dropped only for a gap
  task automatic send_rect(rect_t r);
    int gap;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    cell_rects_due.push_back(cover_rect(r));
  endtask

  // sink side: random stalls, checks every output transfer
  initial begin : sink
    rect_t got;
    rect_t want;
    int    stall;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      got = m_axis_tdata;
      if (cell_rects_due.size() == 0) begin
        $display("unexpected output transfer %h at %0t", got, $time);
        mismatches++;
      end else begin
        want = cell_rects_due.pop_front();
        if (got.min_x !== want.min_x) report_mismatch("cell_min_x", got.min_x, want.min_x);
        if (got.min_y !== want.min_y) report_mismatch("cell_min_y", got.min_y, want.min_y);
        if (got.max_x !== want.max_x) report_mismatch("cell_max_x", got.max_x, want.max_x);
        if (got.max_y !== want.max_y) report_mismatch("cell_max_y", got.max_y, want.max_y);
      end
    end
  end

  function automatic word_t random_edge();
    word_t w;
    w = $urandom();
    case ($urandom_range(0, 5))
      0: w[30:23] = 8'(127 + $urandom_range(0, 31)); // fractional, integral, or at the 2^31 limit
      1: w[30:23] = 8'(120 + $urandom_range(0, 7));  // below two, mostly below one
      2: w[30:23] = 8'(148 + $urandom_range(0, 14)); // near the 2^31 limit
      3: w[30:23] = $urandom_range(0, 1) ? EXP_ALL1 : 8'h00;
      4: w[22:0] = $urandom_range(0, 1) ? 23'h7FFFFF : 23'h0; // mantissa all ones (carry into exponent) or zero
      default: ;
    endcase
    return w;
  endfunction

  task automatic test_directed();
    word_t edge_vals[$];
    edge_vals = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h8000_0001,
      32'h3F00_0000, 32'hBF00_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3FC0_0000,
      32'hBFC0_0000, 32'hBF7F_FFFF, 32'hC07F_FFFF, 32'h7F80_0000, 32'hFF80_0000,
      32'h7FC0_0001, 32'hFFFF_FFFF, 32'h4F00_0000, 32'hCF00_0000, 32'h4EFF_FFFF,
      32'hCEFF_FFFF, 32'h4B00_0001, 32'h7F7F_FFFF};
    foreach (edge_vals[i])
      send_rect('{edge_vals[(i+3) % edge_vals.size()], edge_vals[i],
                  edge_vals[(i+1) % edge_vals.size()], edge_vals[(i+2) % edge_vals.size()]});
  endtask

  task automatic test_random();
    repeat (750) send_rect('{random_edge(), random_edge(), random_edge(), random_edge()});
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (cell_rects_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("Verification failed");
    $finish;
  end
endmodule

>>> float_box_to_cell_box_top.f
src/fbcb_pkg.sv
src/fbcb_lane.sv
src/fbcb_merge.sv
src/float_box_to_cell_box_top.sv
tb/float_box_to_cell_box_top_tb.sv
